// ===== rtl/core/pdhg_pkg.sv =====
// Shared types and constants for the pointer drag-and-hold gesture block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package pdhg_pkg;

  // Field widths
  localparam int POS_W      = 16;
  localparam int TIME_W     = 48;
  localparam int THRESH_W   = 16;
  localparam int HOLD_W     = 32;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Stream words, padded to whole bytes
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GESTURE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_US   = 2'd2;

  // Configuration reset values
  localparam logic                RST_GESTURE_ENABLE = 1'b1;
  localparam logic [THRESH_W-1:0] RST_MOVE_THRESHOLD = 16'd20;
  localparam logic [HOLD_W-1:0]   RST_HOLD_TIME_US   = 32'd2000000;

  // Direction codes
  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_NEG  = 2'sb11;

  // One pointer sample
  typedef struct packed {
    logic [TIME_W-1:0]       time_us;
    logic                    middle_down;
    logic                    right_down;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } pdhg_sample_t;

  // Drag gesture outcome for one sample
  typedef struct packed {
    logic                    fire;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } pdhg_gest_t;

endpackage

// ===== rtl/core/pdhg_drag.sv =====
// Middle-button drag recognizer: anchor, move detection and release directions.
// Depends on pdhg_pkg for the sample and gesture result types.
`timescale 1ns / 1ps

module pdhg_drag (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           enable,
  input  logic [pdhg_pkg::THRESH_W-1:0]  threshold,
  input  pdhg_pkg::pdhg_sample_t         sample,
  output pdhg_pkg::pdhg_gest_t           gest
);
  import pdhg_pkg::*;

  logic                  drag_active;
  logic                  moved_past;
  logic signed [POS_W-1:0] anchor_x;
  logic signed [POS_W-1:0] anchor_y;

  logic signed [POS_W:0] dist_x;
  logic signed [POS_W:0] dist_y;
  logic [POS_W:0]        mag_x;
  logic [POS_W:0]        mag_y;
  logic                  over_x;
  logic                  over_y;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic                  release_fire;

  // Offsets from the anchor need one extra bit
  assign dist_x = {sample.pos_x[POS_W-1], sample.pos_x} - {anchor_x[POS_W-1], anchor_x};
  assign dist_y = {sample.pos_y[POS_W-1], sample.pos_y} - {anchor_y[POS_W-1], anchor_y};
  assign mag_x  = dist_x[POS_W] ? -dist_x : dist_x;
  assign mag_y  = dist_y[POS_W] ? -dist_y : dist_y;
  assign over_x = mag_x > {1'b0, threshold};
  assign over_y = mag_y > {1'b0, threshold};
  assign dir_x  = over_x ? (dist_x[POS_W] ? DIR_NEG : DIR_POS) : DIR_NONE;
  assign dir_y  = over_y ? (dist_y[POS_W] ? DIR_NEG : DIR_POS) : DIR_NONE;

  assign release_fire = enable && drag_active && !sample.middle_down && moved_past &&
                        (over_x || over_y);

  assign gest.fire = release_fire;
  assign gest.dx   = release_fire ? dir_x : DIR_NONE;
  assign gest.dy   = release_fire ? dir_y : DIR_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_active <= 1'b0;
      moved_past  <= 1'b0;
    end else if (advance) begin
      if (!enable) begin
        drag_active <= 1'b0;
        moved_past  <= 1'b0;
      end else if (!drag_active) begin
        if (sample.middle_down) begin
          drag_active <= 1'b1;
          moved_past  <= 1'b0;
        end
      end else if (!sample.middle_down) begin
        drag_active <= 1'b0;
        moved_past  <= 1'b0;
      end else if (over_x || over_y) begin
        moved_past <= 1'b1;
      end
    end
  end

  // Anchor latches on press; it is only read while a drag is active
  always_ff @(posedge clk) begin
    if (advance && enable && !drag_active && sample.middle_down) begin
      anchor_x <= sample.pos_x;
      anchor_y <= sample.pos_y;
    end
  end

endmodule

// ===== rtl/core/pointer_drag_and_hold_gesture.sv =====
// Pointer drag-and-hold gesture recognizer, top level.
// Depends on pdhg_pkg and pdhg_drag.
//
//   channel   | direction | contents
//   ----------+-----------+-------------------------------------------------
//   s_axis    | in        | one pointer sample per transfer
//   m_axis    | out       | one result per sample (hold and gesture fields)
//   cfg       | in        | register writes: enable, threshold, hold time
//
// An input transfer reaches its result on m_axis through the sample register
// and then the result register. One sample per cycle is sustained while
// m_axis does not stall; the limit is the single 48-bit elapsed-time subtract and
// compare between the sample register and the result register.
// rst is synchronous; it clears both valid flags and the button and drag state,
// and returns the configuration registers to their reset values. When m_axis
// stalls the result register holds, the sample register fills, and
// s_axis_tready then drops.
`timescale 1ns / 1ps

module pointer_drag_and_hold_gesture (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [32] right_down, [33] middle_down,
  // [81:34] time_us, [87:82] zero
  input  logic [pdhg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] hold_event, [16:1] hold_x, [32:17] hold_y, [33] gesture_event,
  // [35:34] gesture_dx, [37:36] gesture_dy, [39:38] zero
  output logic [pdhg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [pdhg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdhg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdhg_pkg::*;

  // Configuration registers
  logic                gesture_enable;
  logic [THRESH_W-1:0] move_threshold;
  logic [HOLD_W-1:0]   hold_time_us;

  // Sample register
  logic         s1_valid;
  pdhg_sample_t s1_sample;
  pdhg_sample_t in_sample;
  logic         s1_advance;
  logic         out_ready;

  // Right-button hold state
  logic              right_held;
  logic              hold_fired;
  logic [TIME_W-1:0] right_press_time;
  logic [TIME_W-1:0] elapsed;
  logic              hold_fire;

  pdhg_gest_t gest;

  // Result register
  logic                    res_hold_event;
  logic signed [POS_W-1:0] res_hold_x;
  logic signed [POS_W-1:0] res_hold_y;
  pdhg_gest_t              res_gest;

  // Configuration writes; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_enable <= RST_GESTURE_ENABLE;
      move_threshold <= RST_MOVE_THRESHOLD;
      hold_time_us   <= RST_HOLD_TIME_US;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GESTURE_ENABLE: gesture_enable <= cfg_data[0];
        REG_MOVE_THRESHOLD: move_threshold <= cfg_data[THRESH_W-1:0];
        REG_HOLD_TIME_US:   hold_time_us   <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the sample register advances whenever the result register
  // is empty or being drained this cycle
  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s1_advance    = s1_valid && out_ready;
  assign s_axis_tready = !s1_valid || out_ready;

  assign in_sample = s_axis_tdata[$bits(pdhg_sample_t)-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_sample <= in_sample;
    end
  end

  // Elapsed time wraps modulo 2^48; never checked on the press sample itself
  assign elapsed   = s1_sample.time_us - right_press_time;
  assign hold_fire = s1_sample.right_down && right_held && !hold_fired &&
                     (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold_time_us});

  always_ff @(posedge clk) begin
    if (rst) begin
      right_held <= 1'b0;
      hold_fired <= 1'b0;
    end else if (s1_advance) begin
      if (s1_sample.right_down) begin
        if (!right_held) begin
          right_held <= 1'b1;
          hold_fired <= 1'b0;
        end else if (hold_fire) begin
          hold_fired <= 1'b1;
        end
      end else begin
        right_held <= 1'b0;
        hold_fired <= 1'b0;
      end
    end
  end

  // Press time only matters while right_held is set
  always_ff @(posedge clk) begin
    if (s1_advance && s1_sample.right_down && !right_held) begin
      right_press_time <= s1_sample.time_us;
    end
  end

  pdhg_drag u_drag (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_advance),
    .enable    (gesture_enable),
    .threshold (move_threshold),
    .sample    (s1_sample),
    .gest      (gest)
  );

  // Result register: load on advance, drop valid once drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_hold_event <= hold_fire;
      res_hold_x     <= hold_fire ? s1_sample.pos_x : '0;
      res_hold_y     <= hold_fire ? s1_sample.pos_y : '0;
      res_gest       <= gest;
    end
  end

  assign m_axis_tdata = {2'b00, res_gest.dy, res_gest.dx, res_gest.fire,
                         res_hold_y, res_hold_x, res_hold_event};

`ifndef SYNTH
  // A quiet hold result carries no position
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !res_hold_event |-> (res_hold_x == '0) && (res_hold_y == '0))
    else $error("hold position set without hold event");

  // A fired hold is remembered so it cannot fire again during this press
  assert property (@(posedge clk) disable iff (rst)
    s1_advance && hold_fire |=> hold_fired && right_held)
    else $error("hold fired but hold state not recorded");

  // A completed gesture always points somewhere
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_gest.fire |-> (res_gest.dx != DIR_NONE) || (res_gest.dy != DIR_NONE))
    else $error("gesture event with no direction");

  // An empty result register never blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ===== bench/pointer_drag_and_hold_gesture_tb.sv =====
// Self-checking bench for pointer_drag_and_hold_gesture: directed rows, then random
// pointer traffic over several register settings. Depends on pdhg_pkg and the block RTL.
`timescale 1ns / 1ps

module pointer_drag_and_hold_gesture_tb;
  import pdhg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 62;
  localparam int PAD_W          = IN_TDATA_W - $bits(pdhg_sample_t);

  // One result word as it sits on m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [1:0]              spare;
    logic signed [DIR_W-1:0] dy;
    logic signed [DIR_W-1:0] dx;
    logic                    gest;
    logic signed [POS_W-1:0] hy;
    logic signed [POS_W-1:0] hx;
    logic                    hold;
  } outcome_t;

  localparam outcome_t NO_EVENT = '0;

  typedef struct {
    pdhg_sample_t s;
    bit           typed;
    outcome_t     want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pointer_drag_and_hold_gesture dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: configuration and button/drag state, advanced once per
  // accepted sample in transfer order.
  // ---------------------------------------------------------------------------
  logic                cf_enable;
  logic [THRESH_W-1:0] cf_thresh;
  logic [HOLD_W-1:0]   cf_hold;

  logic                rb_held;
  logic                hold_done;
  logic [TIME_W-1:0]   press_stamp;
  logic                drag_on;
  logic signed [POS_W-1:0] anchor_x;
  logic signed [POS_W-1:0] anchor_y;
  logic                drag_moved;

  outcome_t results_due[$];
  int       error_count = 0;
  int       stall_cycles = 0;

  // Values travelling with the sample currently offered on s_axis.
  bit       offer_typed = 1'b0;
  outcome_t offer_want = '0;

  // Sender gap and receiver stall rates, in percent.
  int gap_pct = 0;
  int stall_pct = 0;

  function automatic logic signed [DIR_W-1:0] axis_sign(input int d);
    int m;
    m = (d < 0) ? -d : d;
    if (m > int'(cf_thresh)) return (d > 0) ? DIR_POS : DIR_NEG;
    return DIR_NONE;
  endfunction

  // Advance the shadow state by one sample and return the result it causes.
  function automatic outcome_t track_sample(input pdhg_sample_t s);
    outcome_t          r;
    logic [TIME_W-1:0] elapsed;
    int                ddx;
    int                ddy;
    r = '0;
    elapsed = s.time_us - press_stamp;
    if (s.right_down) begin
      if (!rb_held) begin
        // press sample: record the stamp, never check the hold here
        rb_held = 1'b1;
        hold_done = 1'b0;
        press_stamp = s.time_us;
      end else if (!hold_done && elapsed >= {{(TIME_W-HOLD_W){1'b0}}, cf_hold}) begin
        hold_done = 1'b1;
        r.hold = 1'b1;
        r.hx = s.pos_x;
        r.hy = s.pos_y;
      end
    end else if (rb_held) begin
      rb_held = 1'b0;
      hold_done = 1'b0;
    end

    ddx = int'(s.pos_x) - int'(anchor_x);
    ddy = int'(s.pos_y) - int'(anchor_y);
    if (!cf_enable) begin
      // disabled: drop the drag, keep the anchor
      drag_on = 1'b0;
      drag_moved = 1'b0;
    end else if (!drag_on) begin
      if (s.middle_down) begin
        anchor_x = s.pos_x;
        anchor_y = s.pos_y;
        drag_moved = 1'b0;
        drag_on = 1'b1;
      end
    end else if (!s.middle_down) begin
      if (drag_moved) begin
        r.dx = axis_sign(ddx);
        r.dy = axis_sign(ddy);
        r.gest = (r.dx != DIR_NONE) || (r.dy != DIR_NONE);
      end
      drag_on = 1'b0;
      drag_moved = 1'b0;
    end else if (!drag_moved && (axis_sign(ddx) != DIR_NONE || axis_sign(ddy) != DIR_NONE)) begin
      drag_moved = 1'b1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    error_count++;
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Register writes update
  // the shadow configuration, input transfers push an expectation, output
  // transfers pop and compare field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    outcome_t calc;
    if (rst) begin
      cf_enable   = RST_GESTURE_ENABLE;
      cf_thresh   = RST_MOVE_THRESHOLD;
      cf_hold     = RST_HOLD_TIME_US;
      rb_held     = 1'b0;
      hold_done   = 1'b0;
      press_stamp = '0;
      drag_on     = 1'b0;
      anchor_x    = '0;
      anchor_y    = '0;
      drag_moved  = 1'b0;
      results_due.delete();
      stall_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GESTURE_ENABLE: cf_enable = cfg_data[0];
          REG_MOVE_THRESHOLD: cf_thresh = cfg_data[THRESH_W-1:0];
          REG_HOLD_TIME_US:   cf_hold   = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        calc = track_sample(pdhg_sample_t'(s_axis_tdata[$bits(pdhg_sample_t)-1:0]));
        // rows with a hand-written result are held to that value instead
        results_due.push_back(offer_typed ? offer_want : calc);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = outcome_t'(m_axis_tdata);
        if (results_due.size() == 0) begin
          flag_mismatch("result with nothing pending", 0, longint'(m_axis_tdata));
        end else begin
          want = results_due.pop_front();
          if (got.hold !== want.hold) flag_mismatch("hold_event", want.hold, got.hold);
          if (got.hx !== want.hx)     flag_mismatch("hold_x", want.hx, got.hx);
          if (got.hy !== want.hy)     flag_mismatch("hold_y", want.hy, got.hy);
          if (got.gest !== want.gest) flag_mismatch("gesture_event", want.gest, got.gest);
          if (got.dx !== want.dx)     flag_mismatch("gesture_dx", want.dx, got.dx);
          if (got.dy !== want.dy)     flag_mismatch("gesture_dy", want.dy, got.dy);
        end
      end

      // count cycles with no transfer of any kind
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Receiver: decide tready for the coming edge at each falling edge.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a long run of edges with no transfer means the block hung.
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  script_row_t script[$];

  // Random walk state: current pointer, buttons and clock.
  logic signed [POS_W-1:0] walk_x = '0;
  logic signed [POS_W-1:0] walk_y = '0;
  logic                    walk_r = 1'b0;
  logic                    walk_m = 1'b0;
  logic [TIME_W-1:0]       walk_t = '0;
  logic [THRESH_W-1:0]     walk_thresh = RST_MOVE_THRESHOLD;
  logic [HOLD_W-1:0]       walk_hold = RST_HOLD_TIME_US;

  function automatic outcome_t mk_outcome(input bit hold, input int hx, input int hy,
                                          input bit gest, input logic signed [DIR_W-1:0] dx,
                                          input logic signed [DIR_W-1:0] dy);
    outcome_t r;
    r = '0;
    r.hold = hold;
    r.hx = POS_W'(hx);
    r.hy = POS_W'(hy);
    r.gest = gest;
    r.dx = dx;
    r.dy = dy;
    return r;
  endfunction

  task automatic add_row(input int x, input int y, input bit r, input bit m,
                         input logic [TIME_W-1:0] t, input bit typed, input outcome_t want);
    script_row_t row;
    row.s.pos_x = POS_W'(x);
    row.s.pos_y = POS_W'(y);
    row.s.right_down = r;
    row.s.middle_down = m;
    row.s.time_us = t;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endtask

  // Next sample of a pointer session: mostly short moves around the threshold,
  // button presses that last a few samples, and clock steps sized to the hold
  // time; now and then a teleport, a clock jump or a random button pattern.
  function automatic pdhg_sample_t roll_sample();
    pdhg_sample_t s;
    int           span;
    logic [63:0]  wide;
    span = int'(walk_thresh) + 4;
    case ($urandom_range(9))
      0, 1: begin
        walk_x = POS_W'($urandom);
        walk_y = POS_W'($urandom);
      end
      2: ;
      default: begin
        walk_x = walk_x + POS_W'(int'($urandom_range(2 * span)) - span);
        walk_y = walk_y + POS_W'(int'($urandom_range(2 * span)) - span);
      end
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: walk_t = walk_t + TIME_W'($urandom_range(1000));
      4, 5, 6, 7: walk_t = walk_t + TIME_W'($urandom_range(walk_hold / 2 + 1));
      8: begin
        wide = {$urandom, $urandom};
        walk_t = walk_t + wide[TIME_W-1:0];
      end
      default: begin
        wide = {$urandom, $urandom};
        walk_t = wide[TIME_W-1:0];
      end
    endcase
    if ($urandom_range(99) < 5) begin
      walk_r = ($urandom_range(1) != 0);
      walk_m = ($urandom_range(1) != 0);
    end else begin
      if ($urandom_range(99) < 20) walk_r = !walk_r;
      if ($urandom_range(99) < 25) walk_m = !walk_m;
    end
    s.pos_x = walk_x;
    s.pos_y = walk_y;
    s.right_down = walk_r;
    s.middle_down = walk_m;
    s.time_us = walk_t;
    return s;
  endfunction

  // Offer one sample at the falling edge, after a random gap, and hold it
  // until the edge that transfers it.
  task automatic send_sample(input pdhg_sample_t s, input bit typed, input outcome_t want);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, s};
    offer_typed   <= typed;
    offer_want    <= want;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Drop valid and wait until every pending result has come out.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges. Upper data bits carry
  // junk that the block must ignore.
  task automatic load_settings(input bit en, input logic [THRESH_W-1:0] thr,
                               input logic [HOLD_W-1:0] hold);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GESTURE_ENABLE;
    cfg_data  <= {junk[CFG_DATA_W-1:1], en};
    @(negedge clk);
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_data  <= {junk[CFG_DATA_W-1:THRESH_W], thr};
    @(negedge clk);
    cfg_index <= REG_HOLD_TIME_US;
    cfg_data  <= CFG_DATA_W'(hold);
    @(negedge clk);
    cfg_we    <= 1'b0;
    walk_thresh = thr;
    walk_hold = hold;
  endtask

  initial begin
    bit                  en_set[7];
    logic [THRESH_W-1:0] thr_set[7];
    logic [HOLD_W-1:0]   hold_set[7];

    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows under the reset settings (enable on, threshold 20,
    // hold 2 s).
    // quiet sample straight after reset
    add_row(0, 0, 0, 0, 48'd0, 1, NO_EVENT);
    // right press at the position extremes: press sample never fires
    add_row(32767, -32768, 1, 0, 48'd100, 1, NO_EVENT);
    // one microsecond short of the hold time
    add_row(32767, -32768, 1, 0, 48'd2000099, 1, NO_EVENT);
    // hold time reached: fire with the current position
    add_row(-32768, 32767, 1, 0, 48'd2000100, 1, mk_outcome(1, -32768, 32767, 0, DIR_NONE,
                                                            DIR_NONE));
    // the hold fires only once per press
    add_row(5, 5, 1, 0, 48'd9000000, 1, NO_EVENT);
    add_row(5, 5, 0, 0, 48'd9000001, 1, NO_EVENT);
    // drag: exactly the threshold is not a move, one past it is
    add_row(0, 0, 0, 1, 48'd9000002, 0, NO_EVENT);
    add_row(20, -20, 0, 1, 48'd9000003, 0, NO_EVENT);
    add_row(21, 0, 0, 1, 48'd9000004, 0, NO_EVENT);
    add_row(21, -21, 0, 0, 48'd9000005, 1, mk_outcome(0, 0, 0, 1, DIR_POS, DIR_NEG));
    // moved, but released back on the anchor: no event
    add_row(100, 100, 0, 1, 48'd9000006, 0, NO_EVENT);
    add_row(100, 300, 0, 1, 48'd9000007, 0, NO_EVENT);
    add_row(100, 100, 0, 0, 48'd9000008, 1, NO_EVENT);
    // corner to corner drag
    add_row(-32768, -32768, 0, 1, 48'd9000009, 0, NO_EVENT);
    add_row(32767, 32767, 0, 1, 48'd9000010, 0, NO_EVENT);
    add_row(32767, -32768, 0, 0, 48'd9000011, 1, mk_outcome(0, 0, 0, 1, DIR_POS, DIR_NONE));
    // left and down
    add_row(0, 0, 0, 1, 48'd9000012, 0, NO_EVENT);
    add_row(-21, -21, 0, 1, 48'd9000013, 0, NO_EVENT);
    add_row(-21, 21, 0, 0, 48'd9000014, 1, mk_outcome(0, 0, 0, 1, DIR_NEG, DIR_POS));
    // hold across the timestamp wrap
    add_row(0, 0, 1, 0, 48'hFFFF_FFFF_FFF6, 0, NO_EVENT);
    add_row(0, 0, 1, 0, 48'hFFFF_FFFF_FFFF, 0, NO_EVENT);
    add_row(1, 2, 1, 0, 48'd1999989, 0, NO_EVENT);
    add_row(3, 4, 1, 0, 48'd1999990, 1, mk_outcome(1, 3, 4, 0, DIR_NONE, DIR_NONE));
    // a stamp earlier than the press reads as a huge elapsed time
    add_row(0, 0, 0, 0, 48'd1999991, 0, NO_EVENT);
    add_row(0, 0, 1, 0, 48'd5000, 0, NO_EVENT);
    add_row(-1, -1, 1, 1, 48'd4999, 1, mk_outcome(1, -1, -1, 0, DIR_NONE, DIR_NONE));

    gap_pct = 21;
    stall_pct = 21;
    foreach (script[i]) send_sample(script[i].s, script[i].typed, script[i].want);
    drain();

    // Register settings per phase: extremes first, then a random one.
    en_set   = '{1, 1, 0, 1, 1, 0, 1};
    thr_set  = '{16'd20, 16'd0, 16'd20, 16'hFFFF, 16'd3, 16'hFFFF, 16'd0};
    hold_set = '{32'd2000000, 32'd0, 32'd1000, 32'hFFFF_FFFF, 32'd500, 32'd0, 32'd0};
    thr_set[6]  = THRESH_W'($urandom_range(40));
    hold_set[6] = HOLD_W'($urandom_range(5000));

    for (int p = 0; p < 7; p++) begin
      load_settings(en_set[p], thr_set[p], hold_set[p]);
      // rotate through the idling patterns: none, sender gaps, receiver stalls, both
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      repeat (PHASE_ITEMS) send_sample(roll_sample(), 1'b0, NO_EVENT);
      drain();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pdhg_pkg.sv
rtl/core/pdhg_drag.sv
rtl/core/pointer_drag_and_hold_gesture.sv
bench/pointer_drag_and_hold_gesture_tb.sv
